FILE: rtl/ddo_pkg.sv
// ddo_pkg: types, constants and the arctangent table of the odometry step
// used by the divider, wrap and cordic cells and by the top level
// no dependencies

package ddo_pkg;

    // quotient bits of the turn divider (magnitude of (l-r)*t*K_TURN)
    localparam int DIV_BITS = 44;
    // width of the biased angle in 2^-24 degree
    localparam int PHI_W    = 42;

    localparam logic [23:0] K_TURN       = 24'd15380219;
    localparam logic [32:0] FULL_TURN    = 33'd6039797760;
    localparam logic [32:0] HALF_TURN    = 33'd3019898880;
    localparam logic [32:0] QUARTER_TURN = 33'd1509949440;
    // 256 full turns, lifts every reachable angle above zero
    localparam logic [PHI_W-1:0] PHI_BIAS = 42'd1546188226560;
    localparam int WRAP_CELLS = 9;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    // degrees (2^-24) to radians Q30, scaled by 2^32
    localparam logic [63:0] DEG_TO_RAD =
        (PI_Q60 + 64'd90 * (64'd1 << 22)) / (64'd180 * (64'd1 << 22));
    localparam logic [32:0] DEG_TO_RAD_Q = DEG_TO_RAD[32:0];

    localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;
    // ceil(2^40 / 1000), exact for dividends below 2^30
    localparam logic [30:0] RECIP_1000 = 31'd1099511628;

    typedef struct packed {
        logic [15:0]         rem;
        logic [DIV_BITS-1:0] nq;
    } div_state_t;

    typedef struct packed {
        logic               neg_turn;
        logic signed [17:0] hd;
        logic signed [27:0] dnum;
    } div_side_t;

    typedef struct packed {
        logic signed [24:0] td;
        logic signed [27:0] dnum;
    } wrap_side_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [32:0] z;
    } cordic_state_t;

    typedef struct packed {
        logic               neg;
        logic signed [24:0] td;
        logic signed [27:0] dnum;
    } cordic_side_t;

    // atan(2^-i) in Q30 radians
    function automatic logic signed [32:0] atan_q30(input int i);
        logic signed [32:0] a;
        case (i)
            0:       a = 33'sd843314857;
            1:       a = 33'sd497837829;
            2:       a = 33'sd263043837;
            3:       a = 33'sd133525159;
            4:       a = 33'sd67021687;
            5:       a = 33'sd33543516;
            6:       a = 33'sd16775851;
            7:       a = 33'sd8388437;
            8:       a = 33'sd4194283;
            9:       a = 33'sd2097149;
            default: a = 33'sd1 <<< (30 - i);
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/ddo_div_cell.sv
// ddo_div_cell: one restoring step of the turn divider, one quotient bit
// depends on ddo_pkg

module ddo_div_cell
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [15:0]            divisor,
    input  logic                   in_valid,
    input  ddo_pkg::div_state_t    in_st,
    input  ddo_pkg::div_side_t     in_side,
    output logic                   out_valid,
    output ddo_pkg::div_state_t    out_st,
    output ddo_pkg::div_side_t     out_side
);

    logic                valid_reg;
    ddo_pkg::div_state_t st_reg;
    ddo_pkg::div_state_t st_next;
    ddo_pkg::div_side_t  side_reg;
    logic [16:0]         trial;
    logic                ge;

    // shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial        = {in_st.rem, in_st.nq[ddo_pkg::DIV_BITS-1]};
        ge           = trial >= {1'b0, divisor};
        st_next.rem  = ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
        st_next.nq   = {in_st.nq[ddo_pkg::DIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg   <= st_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_side  = side_reg;

endmodule

FILE: rtl/ddo_wrap_cell.sv
// ddo_wrap_cell: removes one power-of-two multiple of a full turn if it fits
// depends on ddo_pkg

module ddo_wrap_cell #(
    parameter int SHIFT = 0
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ddo_pkg::PHI_W-1:0]   in_phi,
    input  ddo_pkg::wrap_side_t         in_side,
    output logic                        out_valid,
    output logic [ddo_pkg::PHI_W-1:0]   out_phi,
    output ddo_pkg::wrap_side_t         out_side
);

    localparam logic [ddo_pkg::PHI_W-1:0] STEP =
        ddo_pkg::PHI_W'(ddo_pkg::FULL_TURN) << SHIFT;

    logic                        valid_reg;
    logic [ddo_pkg::PHI_W-1:0]   phi_reg;
    logic [ddo_pkg::PHI_W-1:0]   phi_next;
    ddo_pkg::wrap_side_t         side_reg;

    // conditional subtract of the turn multiple
    always_comb
    begin
        phi_next = (in_phi >= STEP) ? in_phi - STEP : in_phi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg  <= phi_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_phi   = phi_reg;
    assign out_side  = side_reg;

endmodule

FILE: rtl/ddo_cordic_cell.sv
// ddo_cordic_cell: one rotation stage of the sine/cosine cordic
// depends on ddo_pkg

module ddo_cordic_cell #(
    parameter int IDX = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  ddo_pkg::cordic_state_t    in_st,
    input  ddo_pkg::cordic_side_t     in_side,
    output logic                      out_valid,
    output ddo_pkg::cordic_state_t    out_st,
    output ddo_pkg::cordic_side_t     out_side
);

    localparam logic signed [32:0] ANGLE = ddo_pkg::atan_q30(IDX);

    logic                      valid_reg;
    ddo_pkg::cordic_state_t    st_reg;
    ddo_pkg::cordic_state_t    st_next;
    ddo_pkg::cordic_side_t     side_reg;
    logic signed [31:0]        xs;
    logic signed [31:0]        ys;

    // rotate toward zero residual angle
    always_comb
    begin
        xs = in_st.x >>> IDX;
        ys = in_st.y >>> IDX;
        if (!in_st.z[32])
        begin
            st_next.x = in_st.x - ys;
            st_next.y = in_st.y + xs;
            st_next.z = in_st.z - ANGLE;
        end
        else
        begin
            st_next.x = in_st.x + ys;
            st_next.y = in_st.y - xs;
            st_next.z = in_st.z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg   <= st_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_side  = side_reg;

endmodule

FILE: rtl/differential_drive_odometry_step.sv
// differential_drive_odometry_step: top level, odometry step for two wheels
// depends on ddo_pkg, ddo_div_cell, ddo_wrap_cell, ddo_cordic_cell
//
//  channel   direction  fields (low bit first)
//  s_axis    in         left_speed, right_speed, elapsed_ms, heading
//  m_axis    out        step_x, step_y, turn_delta
//  cfg       in         wheel_base
//
//  one transfer per cycle in each direction when neither side stalls
//  the pipeline is made of 44 divider cells, 9 angle wrap cells, the cordic
//  cells and 9 arithmetic stages
//  reset clears every stage valid and loads wheel_base with 5000
//  a stall on m_axis freezes the whole chain and drops s_axis_tready

module differential_drive_odometry_step #(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // left_speed, right_speed, elapsed_ms, heading
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // step_x, step_y, turn_delta, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data        // wheel_base
);

    localparam int DB = ddo_pkg::DIV_BITS;
    localparam int WC = ddo_pkg::WRAP_CELLS;

    logic        en;
    logic [15:0] wb_reg;
    logic [15:0] wb_eff;

    // chain advances unless the output is held
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // wheel base register, small values clamp to 16
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg <= 16'd5000;
        end
        else if (cfg_valid)
        begin
            wb_reg <= cfg_data;
        end
    end

    assign wb_eff = (wb_reg < 16'd16) ? 16'd16 : wb_reg;

    // stage 1: wheel difference and sum times time
    logic signed [9:0]  in_l;
    logic signed [9:0]  in_r;
    logic [9:0]         in_t;
    logic signed [10:0] diff;
    logic signed [10:0] sum;
    logic [9:0]         dmag;
    logic signed [21:0] st_prod;
    logic               s1_v_reg;
    logic [19:0]        s1_dtm_reg;
    logic               s1_neg_reg;
    logic signed [17:0] s1_hd_reg;
    logic signed [27:0] s1_dnum_reg;

    always_comb
    begin
        in_l    = s_axis_tdata[9:0];
        in_r    = s_axis_tdata[19:10];
        in_t    = s_axis_tdata[29:20];
        diff    = 11'(in_l) - 11'(in_r);
        sum     = 11'(in_l) + 11'(in_r);
        dmag    = diff[10] ? 10'(-diff) : diff[9:0];
        st_prod = sum * $signed({1'b0, in_t});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dtm_reg  <= 20'(dmag * in_t);
            s1_neg_reg  <= diff[10];
            s1_hd_reg   <= s_axis_tdata[47:30];
            s1_dnum_reg <= {st_prod[20:0], 7'd0};
        end
    end

    // stage 2: turn numerator magnitude
    logic                s2_v_reg;
    logic [DB-1:0]       s2_mag_reg;
    ddo_pkg::div_side_t  s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mag_reg           <= DB'(s1_dtm_reg) * DB'(ddo_pkg::K_TURN);
            s2_side_reg.neg_turn <= s1_neg_reg;
            s2_side_reg.hd       <= s1_hd_reg;
            s2_side_reg.dnum     <= s1_dnum_reg;
        end
    end

    // divider chain, one quotient bit per cell
    logic                 div_v  [0:DB];
    ddo_pkg::div_state_t  div_st [0:DB];
    ddo_pkg::div_side_t   div_sd [0:DB];

    assign div_v[0]      = s2_v_reg;
    assign div_st[0].rem = 16'd0;
    assign div_st[0].nq  = s2_mag_reg;
    assign div_sd[0]     = s2_side_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DB; gi++)
        begin : g_div
            ddo_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .divisor   (wb_eff),
                .in_valid  (div_v[gi]),
                .in_st     (div_st[gi]),
                .in_side   (div_sd[gi]),
                .out_valid (div_v[gi+1]),
                .out_st    (div_st[gi+1]),
                .out_side  (div_sd[gi+1])
            );
        end
    endgenerate

    // stage 3: rounding, heading change and biased new angle
    logic [16:0]        rnd_sum;
    logic               rbit;
    logic [42:0]        tr_mag;
    logic [28:0]        td_mag;
    logic signed [24:0] td_sat;
    logic signed [42:0] phi_s;
    logic               s3_v_reg;
    logic [ddo_pkg::PHI_W-1:0] s3_phi_reg;
    ddo_pkg::wrap_side_t       s3_side_reg;

    always_comb
    begin
        rnd_sum = {1'b0, div_st[DB].rem} + {1'b0, 1'b0, wb_eff[15:1]};
        rbit    = rnd_sum >= {1'b0, wb_eff};
        tr_mag  = 43'(div_st[DB].nq) + 43'(rbit);
        td_mag  = 29'((45'(div_st[DB].nq) + 45'd32768) >> 16);
        if (div_sd[DB].neg_turn)
        begin
            td_sat = (td_mag > 29'd16777216) ? -25'sd16777216 : 25'(-td_mag);
        end
        else
        begin
            td_sat = (td_mag > 29'd16777215) ? 25'sd16777215 : 25'(td_mag);
        end
        phi_s = (43'(div_sd[DB].hd) <<< 16)
              + (div_sd[DB].neg_turn ? -tr_mag : tr_mag)
              + 43'(ddo_pkg::PHI_BIAS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= div_v[DB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_phi_reg       <= phi_s[ddo_pkg::PHI_W-1:0];
            s3_side_reg.td   <= td_sat;
            s3_side_reg.dnum <= div_sd[DB].dnum;
        end
    end

    // wrap chain, reduces the angle into one turn
    logic                       wr_v   [0:WC];
    logic [ddo_pkg::PHI_W-1:0]  wr_phi [0:WC];
    ddo_pkg::wrap_side_t        wr_sd  [0:WC];

    assign wr_v[0]   = s3_v_reg;
    assign wr_phi[0] = s3_phi_reg;
    assign wr_sd[0]  = s3_side_reg;

    generate
        for (gi = 0; gi < WC; gi++)
        begin : g_wrap
            ddo_wrap_cell #(
                .SHIFT (WC - 1 - gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (wr_v[gi]),
                .in_phi    (wr_phi[gi]),
                .in_side   (wr_sd[gi]),
                .out_valid (wr_v[gi+1]),
                .out_phi   (wr_phi[gi+1]),
                .out_side  (wr_sd[gi+1])
            );
        end
    endgenerate

    // stage 4: center on zero and fold into the right half plane
    logic signed [34:0] pc;
    logic signed [34:0] pf;
    logic               fold;
    logic               s4_v_reg;
    logic [30:0]        s4_amag_reg;
    logic               s4_zneg_reg;
    logic               s4_fold_reg;
    ddo_pkg::wrap_side_t s4_side_reg;

    always_comb
    begin
        pc = (wr_phi[WC] > ddo_pkg::PHI_W'(ddo_pkg::HALF_TURN))
           ? 35'(wr_phi[WC]) - 35'(ddo_pkg::FULL_TURN) : 35'(wr_phi[WC]);
        fold = 1'b0;
        pf   = pc;
        if (pc > $signed(35'(ddo_pkg::QUARTER_TURN)))
        begin
            pf   = pc - 35'(ddo_pkg::HALF_TURN);
            fold = 1'b1;
        end
        else if (pc < -$signed(35'(ddo_pkg::QUARTER_TURN)))
        begin
            pf   = pc + 35'(ddo_pkg::HALF_TURN);
            fold = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= wr_v[WC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_amag_reg <= pf[34] ? 31'(-pf) : pf[30:0];
            s4_zneg_reg <= pf[34];
            s4_fold_reg <= fold;
            s4_side_reg <= wr_sd[WC];
        end
    end

    // stage 5: degrees to radians, cordic seed
    logic [63:0]               rad_prod;
    logic [31:0]               zm;
    logic                      s5_v_reg;
    ddo_pkg::cordic_state_t    s5_st_reg;
    ddo_pkg::cordic_side_t     s5_side_reg;

    always_comb
    begin
        rad_prod = 64'(s4_amag_reg) * 64'(ddo_pkg::DEG_TO_RAD_Q);
        zm       = 32'((rad_prod + 64'd2147483648) >> 32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_st_reg.x      <= ddo_pkg::CORDIC_GAIN;
            s5_st_reg.y      <= 32'sd0;
            s5_st_reg.z      <= s4_zneg_reg ? -33'(zm) : 33'(zm);
            s5_side_reg.neg  <= s4_fold_reg;
            s5_side_reg.td   <= s4_side_reg.td;
            s5_side_reg.dnum <= s4_side_reg.dnum;
        end
    end

    // cordic chain
    logic                    co_v  [0:CORDIC_STAGES];
    ddo_pkg::cordic_state_t  co_st [0:CORDIC_STAGES];
    ddo_pkg::cordic_side_t   co_sd [0:CORDIC_STAGES];

    assign co_v[0]  = s5_v_reg;
    assign co_st[0] = s5_st_reg;
    assign co_sd[0] = s5_side_reg;

    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++)
        begin : g_cordic
            ddo_cordic_cell #(
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (co_v[gi]),
                .in_st     (co_st[gi]),
                .in_side   (co_sd[gi]),
                .out_valid (co_v[gi+1]),
                .out_st    (co_st[gi+1]),
                .out_side  (co_sd[gi+1])
            );
        end
    endgenerate

    // stage 6: unfold and scale by distance
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               s6_v_reg;
    logic signed [59:0] s6_px_reg;
    logic signed [59:0] s6_py_reg;
    logic signed [24:0] s6_td_reg;

    always_comb
    begin
        cx = co_sd[CORDIC_STAGES].neg ? -co_st[CORDIC_STAGES].x : co_st[CORDIC_STAGES].x;
        cy = co_sd[CORDIC_STAGES].neg ? -co_st[CORDIC_STAGES].y : co_st[CORDIC_STAGES].y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_v_reg <= co_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_px_reg <= 60'(co_sd[CORDIC_STAGES].dnum) * 60'(cy);
            s6_py_reg <= 60'(co_sd[CORDIC_STAGES].dnum) * 60'(cx);
            s6_td_reg <= co_sd[CORDIC_STAGES].td;
        end
    end

    // stage 7: magnitude over 2^30 plus half of 1000
    logic [58:0] mx;
    logic [58:0] my;
    logic        s7_v_reg;
    logic [29:0] s7_nx_reg;
    logic [29:0] s7_ny_reg;
    logic        s7_sx_reg;
    logic        s7_sy_reg;
    logic signed [24:0] s7_td_reg;

    always_comb
    begin
        mx = s6_px_reg[59] ? 59'(-s6_px_reg) : s6_px_reg[58:0];
        my = s6_py_reg[59] ? 59'(-s6_py_reg) : s6_py_reg[58:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s7_v_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_nx_reg <= 30'(mx >> 30) + 30'd500;
            s7_ny_reg <= 30'(my >> 30) + 30'd500;
            s7_sx_reg <= s6_px_reg[59];
            s7_sy_reg <= s6_py_reg[59];
            s7_td_reg <= s6_td_reg;
        end
    end

    // stage 8: divide by 1000 through the reciprocal
    logic [60:0] qx_prod;
    logic [60:0] qy_prod;
    logic        s8_v_reg;
    logic [20:0] s8_qx_reg;
    logic [20:0] s8_qy_reg;
    logic        s8_sx_reg;
    logic        s8_sy_reg;
    logic signed [24:0] s8_td_reg;

    always_comb
    begin
        qx_prod = 61'(s7_nx_reg) * 61'(ddo_pkg::RECIP_1000);
        qy_prod = 61'(s7_ny_reg) * 61'(ddo_pkg::RECIP_1000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s8_v_reg <= s7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_qx_reg <= qx_prod[60:40];
            s8_qy_reg <= qy_prod[60:40];
            s8_sx_reg <= s7_sx_reg;
            s8_sy_reg <= s7_sy_reg;
            s8_td_reg <= s7_td_reg;
        end
    end

    // stage 9: sign and saturation into the output register
    logic signed [17:0] sat_x;
    logic signed [17:0] sat_y;
    logic               out_v_reg;
    logic signed [17:0] out_x_reg;
    logic signed [17:0] out_y_reg;
    logic signed [24:0] out_td_reg;

    always_comb
    begin
        if (s8_sx_reg)
        begin
            sat_x = (s8_qx_reg > 21'd131072) ? -18'sd131072 : 18'(-s8_qx_reg);
        end
        else
        begin
            sat_x = (s8_qx_reg > 21'd131071) ? 18'sd131071 : 18'(s8_qx_reg);
        end
        if (s8_sy_reg)
        begin
            sat_y = (s8_qy_reg > 21'd131072) ? -18'sd131072 : 18'(-s8_qy_reg);
        end
        else
        begin
            sat_y = (s8_qy_reg > 21'd131071) ? 18'sd131071 : 18'(s8_qy_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= s8_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg  <= sat_x;
            out_y_reg  <= sat_y;
            out_td_reg <= s8_td_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {3'b000, out_td_reg, out_y_reg, out_x_reg};

endmodule
